@@ hdl/cvl_pkg.sv @@
package cvl_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed widths of the item fields
  localparam int OP_W     = 2;
  localparam int IN_VAL_W = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int OUT_VAL_W = 32;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 2'd0,
    OP_DELETE_ALL = 2'd1,
    OP_REMOVE_AT  = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_VAL_W-1:0]  removed_value;
    logic [COUNT_W-1:0]    count;
  } result_t;

endpackage

@@ hdl/cvl_mem.sv @@
module cvl_mem #(
  parameter int DEPTH       = cvl_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cvl_pkg::VALUE_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/cvl_ctrl.sv @@
module cvl_ctrl #(
  parameter int DEPTH       = cvl_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cvl_pkg::VALUE_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cvl_pkg::OP_W-1:0]        in_operation,
  input  logic [cvl_pkg::IN_VAL_W-1:0]    in_value,
  input  logic [cvl_pkg::INDEX_W-1:0]     in_index,
  input  logic                            res_free,
  output logic                            res_valid,
  output cvl_pkg::result_t                res,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output logic [VALUE_WIDTH-1:0]          mem_wdata,
  output logic                            mem_re,
  output logic [AW-1:0]                   mem_raddr,
  input  logic [VALUE_WIDTH-1:0]          mem_rdata
);

  localparam int ValExtW = (VALUE_WIDTH > cvl_pkg::IN_VAL_W) ? VALUE_WIDTH
                                                             : cvl_pkg::IN_VAL_W;
  localparam int CntExtW = (CW > cvl_pkg::COUNT_W) ? CW : cvl_pkg::COUNT_W;
  localparam int CmpW    = (CW > cvl_pkg::INDEX_W) ? CW : cvl_pkg::INDEX_W;

  cvl_pkg::state_t  state_r, state_nxt;
  cvl_pkg::op_t     op_r, op_nxt;
  cvl_pkg::status_t status_r, status_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [VALUE_WIDTH-1:0] taken_r, taken_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          rd_r, rd_nxt;
  logic [CW-1:0]          wr_r, wr_nxt;
  logic                   rv_r, rv_nxt;
  logic                   first_r, first_nxt;

  cvl_pkg::op_t           in_op;
  logic [ValExtW-1:0]     in_val_ext;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [CmpW-1:0]        idx_ext;
  logic [CmpW-1:0]        cnt_cmp;
  logic                   accept;
  logic                   full;
  logic                   out_of_range;
  logic                   scan_end;
  logic                   drop;
  logic [ValExtW-1:0]     taken_ext;
  logic [CntExtW-1:0]     cnt_ext;

  assign in_op        = cvl_pkg::op_t'(in_operation);
  assign in_val_ext   = ValExtW'(in_value);
  assign in_val       = in_val_ext[VALUE_WIDTH-1:0];
  assign idx_ext      = CmpW'(in_index);
  assign cnt_cmp      = CmpW'(count_r);
  assign accept       = in_valid && !in_stall;
  assign full         = (count_r == CW'(DEPTH));
  assign out_of_range = (idx_ext >= cnt_cmp);
  assign scan_end     = (rd_r == count_r) && !rv_r;
  // remove-at drops only the first entry read, delete-all every match
  assign drop         = first_r || ((op_r == cvl_pkg::OP_DELETE_ALL) &&
                                    (mem_rdata == value_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cvl_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_op == cvl_pkg::OP_DELETE_ALL) ||
              ((in_op == cvl_pkg::OP_REMOVE_AT) && !out_of_range)) begin
            state_nxt = cvl_pkg::ST_SCAN;
          end else begin
            state_nxt = cvl_pkg::ST_DONE;
          end
        end
      end
      cvl_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = cvl_pkg::ST_DONE;
        end
      end
      cvl_pkg::ST_DONE: begin
        if (res_free) begin
          state_nxt = cvl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cvl_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall  = 1'b1;
    res_valid = 1'b0;
    case (state_r)
      cvl_pkg::ST_IDLE: in_stall  = 1'b0;
      cvl_pkg::ST_SCAN: in_stall  = 1'b1;
      cvl_pkg::ST_DONE: res_valid = res_free;
      default:          in_stall  = 1'b1;
    endcase
  end

  // datapath and memory access
  always_comb begin
    op_nxt     = op_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    taken_nxt  = taken_r;
    count_nxt  = count_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    rv_nxt     = rv_r;
    first_nxt  = first_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = rd_r[AW-1:0];
    case (state_r)
      cvl_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          value_nxt  = in_val;
          taken_nxt  = '0;
          status_nxt = cvl_pkg::STATUS_OK;
          rv_nxt     = 1'b0;
          first_nxt  = 1'b0;
          case (in_op)
            cvl_pkg::OP_APPEND: begin
              if (full) begin
                status_nxt = cvl_pkg::STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_val;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            cvl_pkg::OP_DELETE_ALL: begin
              rd_nxt = '0;
              wr_nxt = '0;
            end
            cvl_pkg::OP_REMOVE_AT: begin
              if (out_of_range) begin
                status_nxt = cvl_pkg::STATUS_RANGE;
              end else begin
                rd_nxt    = idx_ext[CW-1:0];
                wr_nxt    = idx_ext[CW-1:0];
                first_nxt = 1'b1;
              end
            end
            default: status_nxt = cvl_pkg::STATUS_OK;
          endcase
        end
      end
      cvl_pkg::ST_SCAN: begin
        if (rd_r < count_r) begin
          mem_re = 1'b1;
          rd_nxt = CW'(rd_r + 1'b1);
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          if (first_r) begin
            taken_nxt = mem_rdata;
          end
          first_nxt = 1'b0;
          // write pointer trails the read pointer, so no unread entry is hit
          if (!drop) begin
            mem_we = 1'b1;
            wr_nxt = CW'(wr_r + 1'b1);
          end
        end
        if (scan_end) begin
          count_nxt = wr_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvl_pkg::ST_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    taken_r  <= taken_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
  end

  assign taken_ext         = ValExtW'(taken_r);
  assign cnt_ext           = CntExtW'(count_r);
  assign res.status        = status_r;
  assign res.removed_value = taken_ext[cvl_pkg::OUT_VAL_W-1:0];
  assign res.count         = cnt_ext[cvl_pkg::COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cvl_pkg::ST_SCAN) |-> (wr_r <= rd_r))
    else $error("write pointer passed read pointer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != cvl_pkg::ST_IDLE))
    else $error("accepted item left no work");

endmodule

@@ hdl/compacting_value_list_core.sv @@
// append, no-op and rejected operations: no scan; result goes to the output register
// delete-all and remove-at: scan from the start entry, one stored entry per cycle
//   through the single read port and single write port of the list memory
// one item in flight; the next item is accepted the cycle after its result is registered
// reset clears the count and control state only; memory contents are undefined until written
module compacting_value_list_core #(
  parameter int DEPTH       = cvl_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cvl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cvl_pkg::OP_W-1:0]      in_operation,
  input  logic [cvl_pkg::IN_VAL_W-1:0]  in_value,
  input  logic [cvl_pkg::INDEX_W-1:0]   in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cvl_pkg::STATUS_W-1:0]  out_status,
  output logic [cvl_pkg::OUT_VAL_W-1:0] out_removed_value,
  output logic [cvl_pkg::COUNT_W-1:0]   out_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   res_free;
  logic                   res_valid;
  cvl_pkg::result_t       res;

  logic                   out_valid_r, out_valid_nxt;
  cvl_pkg::result_t       out_res_r;

  cvl_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cvl_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_index     (in_index),
    .res_free     (res_free),
    .res_valid    (res_valid),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // output register frees up when empty or being taken
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_removed_value = out_res_r.removed_value;
  assign out_count         = out_res_r.count;

endmodule

@@ sim/tb_compacting_value_list_core.sv @@
module tb_compacting_value_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = cvl_pkg::DEPTH_DEF;
  localparam int IDX_W        = $clog2(LIST_DEPTH);
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_SEGMENTS = 8;
  localparam int SEG_ITEMS    = 112;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;

  // operation mix of a random segment
  localparam int MIX_FILL     = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN    = 2;

  typedef struct packed {
    cvl_pkg::op_t     op;
    logic [31:0]      value;
    logic [5:0]       index;
    logic             known;
    cvl_pkg::result_t res;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [cvl_pkg::OP_W-1:0]      in_operation;
  logic [cvl_pkg::IN_VAL_W-1:0]  in_value;
  logic [cvl_pkg::INDEX_W-1:0]   in_index;
  logic                          out_valid;
  logic                          out_stall;
  logic [cvl_pkg::STATUS_W-1:0]  out_status;
  logic [cvl_pkg::OUT_VAL_W-1:0] out_removed_value;
  logic [cvl_pkg::COUNT_W-1:0]   out_count;

  compacting_value_list_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_index          (in_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_count         (out_count)
  );

  // predicted list contents
  logic [31:0]      list_store [LIST_DEPTH];
  int               list_len;
  cvl_pkg::result_t pending_results [$];

  stim_row_t        directed_rows [NUM_DIRECTED];
  logic             cur_known;
  cvl_pkg::result_t cur_known_res;

  int idle_pct;
  int stall_pct;
  bit hold_request;
  int hold_left;

  int mismatches;
  int items_in;
  int results_out;
  int full_hits;
  int range_hits;
  int removals;
  int multi_deletes;
  int peak_len;
  int blocked_cycles;
  int hold_stall_cycles;

  function automatic cvl_pkg::result_t apply_list_op(cvl_pkg::op_t op, logic [31:0] value,
                                                     logic [5:0] index);
    cvl_pkg::result_t r;
    int               wr;
    r.status        = cvl_pkg::STATUS_OK;
    r.removed_value = '0;
    case (op)
      cvl_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = cvl_pkg::STATUS_FULL;
        end else begin
          list_store[IDX_W'(list_len)] = value;
          list_len++;
        end
      end
      cvl_pkg::OP_DELETE_ALL: begin
        wr = 0;
        for (int rd = 0; rd < list_len; rd++) begin
          if (list_store[IDX_W'(rd)] != value) begin
            list_store[IDX_W'(wr)] = list_store[IDX_W'(rd)];
            wr++;
          end
        end
        list_len = wr;
      end
      cvl_pkg::OP_REMOVE_AT: begin
        if (int'(index) >= list_len) begin
          r.status = cvl_pkg::STATUS_RANGE;
        end else begin
          r.removed_value = list_store[index];
          for (int rd = int'(index); rd + 1 < list_len; rd++)
            list_store[IDX_W'(rd)] = list_store[IDX_W'(rd + 1)];
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = list_len[cvl_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic cvl_pkg::op_t pick_op(int mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:     return r < 85 ? cvl_pkg::OP_APPEND : r < 91 ? cvl_pkg::OP_REMOVE_AT :
                           r < 94 ? cvl_pkg::OP_DELETE_ALL : cvl_pkg::OP_NOP;
      MIX_BALANCED: return r < 45 ? cvl_pkg::OP_APPEND : r < 70 ? cvl_pkg::OP_REMOVE_AT :
                           r < 92 ? cvl_pkg::OP_DELETE_ALL : cvl_pkg::OP_NOP;
      default:      return r < 25 ? cvl_pkg::OP_APPEND : r < 60 ? cvl_pkg::OP_REMOVE_AT :
                           r < 96 ? cvl_pkg::OP_DELETE_ALL : cvl_pkg::OP_NOP;
    endcase
  endfunction

  // mostly values already held or from a small pool, so deletes find copies
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40 && list_len > 0) return list_store[IDX_W'($urandom_range(list_len - 1))];
    if (r < 70) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h0000_0001;
        default: return 32'h0000_0007;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [5:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 55 && list_len > 0) return 6'($urandom_range(list_len - 1));
    if (r < 65) return 6'd0;
    if (r < 75 && list_len > 0) return 6'(list_len - 1);
    if (r < 85) return list_len > 63 ? 6'd63 : 6'(list_len);
    return 6'($urandom_range(63));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_item(cvl_pkg::op_t op, logic [31:0] value, logic [5:0] index,
                            logic known, cvl_pkg::result_t known_res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_value      <= value;
    in_index      <= index;
    cur_known     = known;
    cur_known_res = known_res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 74; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 74; end
      default: begin idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        hold_stall_cycles++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cvl_pkg::result_t got;
    cvl_pkg::result_t want;
    cvl_pkg::result_t pred;
    int               len_before;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_out++;
        got.status        = cvl_pkg::status_t'(out_status);
        got.removed_value = out_removed_value;
        got.count         = out_count;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d removed %h count %0d",
                     got.status, got.removed_value, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.removed_value !== want.removed_value ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: status %0d/%0d removed %h/%h count %0d/%0d",
                       results_out, want.status, got.status, want.removed_value,
                       got.removed_value, want.count, got.count);
          end
        end
      end
      if (in_valid && in_stall) blocked_cycles++;
      if (in_valid && !in_stall) begin
        items_in++;
        len_before = list_len;
        pred = apply_list_op(cvl_pkg::op_t'(in_operation), in_value, in_index);
        if (pred.status == cvl_pkg::STATUS_FULL) full_hits++;
        if (pred.status == cvl_pkg::STATUS_RANGE) range_hits++;
        if (cvl_pkg::op_t'(in_operation) == cvl_pkg::OP_REMOVE_AT &&
            pred.status == cvl_pkg::STATUS_OK) removals++;
        if (cvl_pkg::op_t'(in_operation) == cvl_pkg::OP_DELETE_ALL &&
            len_before - list_len > 1) multi_deletes++;
        if (list_len > peak_len) peak_len = list_len;
        pending_results.push_back(cur_known ? cur_known_res : pred);
      end
    end
  end

  initial begin
    cvl_pkg::op_t op;
    logic [31:0]  value;
    logic [5:0]   index;
    int           mix;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = cvl_pkg::OP_NOP;
    in_value      = '0;
    in_index      = '0;
    cur_known     = 1'b0;
    cur_known_res = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    list_len      = 0;

    directed_rows = '{
      '{cvl_pkg::OP_REMOVE_AT,  32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_RANGE, 32'h0, 7'd0}},
      '{cvl_pkg::OP_DELETE_ALL, 32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_NOP,        32'hFFFF_FFFF, 6'd63, 1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_APPEND,     32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd1}},
      '{cvl_pkg::OP_APPEND,     32'hFFFF_FFFF, 6'd63, 1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd2}},
      '{cvl_pkg::OP_APPEND,     32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd3}},
      '{cvl_pkg::OP_APPEND,     32'h5A5A_5A5A, 6'd21, 1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd4}},
      '{cvl_pkg::OP_APPEND,     32'hA5A5_A5A5, 6'd42, 1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      // both zero copies go, the rest close up
      '{cvl_pkg::OP_DELETE_ALL, 32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd3}},
      '{cvl_pkg::OP_REMOVE_AT,  32'h0000_0000, 6'd63, 1'b1,
        '{cvl_pkg::STATUS_RANGE, 32'h0, 7'd3}},
      '{cvl_pkg::OP_REMOVE_AT,  32'hFFFF_FFFF, 6'd3,  1'b1,
        '{cvl_pkg::STATUS_RANGE, 32'h0, 7'd3}},
      '{cvl_pkg::OP_REMOVE_AT,  32'h0000_0000, 6'd2,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'hA5A5_A5A5, 7'd2}},
      '{cvl_pkg::OP_DELETE_ALL, 32'h1234_5678, 6'd0,  1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_APPEND,     32'h8000_0000, 6'd0,  1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_REMOVE_AT,  32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'hFFFF_FFFF, 7'd2}},
      '{cvl_pkg::OP_NOP,        32'h0000_0000, 6'd0,  1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_DELETE_ALL, 32'h5A5A_5A5A, 6'd5,  1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_REMOVE_AT,  32'h0000_0000, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h8000_0000, 7'd0}},
      '{cvl_pkg::OP_APPEND,     32'h0000_0001, 6'd0,  1'b0,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}},
      '{cvl_pkg::OP_DELETE_ALL, 32'h0000_0001, 6'd0,  1'b1,
        '{cvl_pkg::STATUS_OK, 32'h0, 7'd0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
                 directed_rows[i].known, directed_rows[i].res);

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      set_idling(seg % 4);
      case (seg)
        0, 3, 5: mix = MIX_FILL;
        2, 6:    mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off while items keep coming
        if (seg == 4 && n == 20) hold_request = 1'b1;
        op = pick_op(mix);
        value = pick_value();
        index = pick_index();
        offer_item(op, value, index, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items %0d, results %0d, list peak %0d of %0d, full appends %0d, bad indexes %0d",
             items_in, results_out, peak_len, LIST_DEPTH, full_hits, range_hits);
    $display("removals %0d, multi-entry deletes %0d, input blocked %0d cycles, %s %0d cycles",
             removals, multi_deletes, blocked_cycles, "hold-off", hold_stall_cycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ compacting_value_list_core.f @@
hdl/cvl_pkg.sv
hdl/cvl_mem.sv
hdl/cvl_ctrl.sv
hdl/compacting_value_list_core.sv
sim/tb_compacting_value_list_core.sv
